FILE: rtl/deq_pkg.sv
`default_nettype none
package deq_pkg;

    // Word width of a stored element and default queue depth.
    localparam int WORD_W    = 32;
    localparam int DEPTH_DEF = 16;
    localparam int COUNT_W   = 5;

    // Request codes.
    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_BACK   = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [WORD_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } t_res;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic       en;
        logic [1:0] op;
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: rtl/deq_cell.sv
`default_nettype none
module deq_cell (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire deq_pkg::t_cell_ctl             i_ctl,
    input  wire logic signed [deq_pkg::WORD_W-1:0] i_word,
    input  wire logic signed [deq_pkg::WORD_W-1:0] i_left_data,
    input  wire logic                           i_left_valid,
    input  wire logic signed [deq_pkg::WORD_W-1:0] i_right_data,
    input  wire logic                           i_right_valid,
    output logic signed [deq_pkg::WORD_W-1:0]   o_data,
    output logic                                o_valid,
    output logic signed [deq_pkg::WORD_W-1:0]   o_tail_tap
);

    logic signed [deq_pkg::WORD_W-1:0] r_data, n_data;
    logic                              r_valid, n_valid;
    logic                              tail;

    // This cell holds the back element when it is occupied and its right neighbour is not.
    assign tail = r_valid && !i_right_valid;

    // Next contents: shift right, fill the first free cell, shift left or drop the tail.
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.en) begin
            unique case (i_ctl.op)
                deq_pkg::REQ_PUSH_FRONT: begin
                    n_data  = i_left_data;
                    n_valid = i_left_valid;
                end
                deq_pkg::REQ_PUSH_BACK: begin
                    if (!r_valid && i_left_valid) begin
                        n_data  = i_word;
                        n_valid = 1'b1;
                    end
                end
                deq_pkg::REQ_POP_FRONT: begin
                    n_data  = i_right_data;
                    n_valid = i_right_valid;
                end
                deq_pkg::REQ_POP_BACK: begin
                    if (tail) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    // Occupancy flag is control state; the word itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_valid    = r_valid;
    assign o_tail_tap = tail ? r_data : '0;

endmodule
`default_nettype wire

FILE: rtl/double_ended_queue.sv
`default_nettype none
// Result: the result strobe rises in the cycle after a request is accepted.
// Throughput: one request per cycle; busy stays low, and every request finishes in one
// shift of the cell chain, with the back word read through an OR tree over the cells.
// Reset: synchronous, active low; the queue is empty afterwards and no result is pending.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire deq_pkg::t_req i_req,
    output logic               o_valid,
    output deq_pkg::t_res      o_res
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_valid;
    deq_pkg::t_res     r_res, n_res;
    deq_pkg::t_cell_ctl ctl;
    logic              accept, full, empty;
    logic [31:0]       count_ext;

    logic signed [deq_pkg::WORD_W-1:0] cell_data [DEPTH];
    logic                              cell_valid [DEPTH];
    logic signed [deq_pkg::WORD_W-1:0] cell_tap [DEPTH];
    logic signed [deq_pkg::WORD_W-1:0] back_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(DEPTH));
    assign empty  = (r_count == '0);

    // Decode the request into a chain command and the next element count.
    always_comb begin
        ctl.en  = 1'b0;
        ctl.op  = i_req.req_type;
        n_count = r_count;
        n_res.pop_value = '0;
        n_res.status    = deq_pkg::STAT_DONE;
        unique case (i_req.req_type)
            deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
                if (full) begin
                    n_res.status = deq_pkg::STAT_FULL;
                end else begin
                    ctl.en  = accept;
                    n_count = r_count + 1'b1;
                end
            end
            deq_pkg::REQ_POP_FRONT: begin
                if (empty) begin
                    n_res.status = deq_pkg::STAT_EMPTY;
                end else begin
                    ctl.en          = accept;
                    n_count         = r_count - 1'b1;
                    n_res.pop_value = cell_data[0];
                end
            end
            deq_pkg::REQ_POP_BACK: begin
                if (empty) begin
                    n_res.status = deq_pkg::STAT_EMPTY;
                end else begin
                    ctl.en          = accept;
                    n_count         = r_count - 1'b1;
                    n_res.pop_value = back_word;
                end
            end
            default: begin
                ctl.en = 1'b0;
            end
        endcase
        count_ext   = 32'(n_count);
        n_res.count = count_ext[deq_pkg::COUNT_W-1:0];
    end

    // Row of cells: the front element sits in cell 0, the back one in the last occupied cell.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [deq_pkg::WORD_W-1:0] left_data, right_data;
        logic                              left_valid, right_valid;

        if (g == 0) begin : g_head
            assign left_data  = i_req.push_value;
            assign left_valid = 1'b1;
        end else begin : g_inner
            assign left_data  = cell_data[g-1];
            assign left_valid = cell_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid
            assign right_data  = cell_data[g+1];
            assign right_valid = cell_valid[g+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_word        (i_req.push_value),
            .i_left_data   (left_data),
            .i_left_valid  (left_valid),
            .i_right_data  (right_data),
            .i_right_valid (right_valid),
            .o_data        (cell_data[g]),
            .o_valid       (cell_valid[g]),
            .o_tail_tap    (cell_tap[g])
        );
    end

    // Only the tail cell drives a non-zero tap, so an OR gathers the back word.
    always_comb begin
        back_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back_word = back_word | cell_tap[k];
        end
    end

    // Count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result item register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire
